>>> hdl/assert_macros.svh
// assertion helpers included by the edge table core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AMET_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
`define AMET_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AMET_ASSERT(label, clk, rstn, prop)
`define AMET_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> hdl/amet_pkg.sv
`default_nettype none

package amet_pkg;

  localparam int NODE_W   = 4;
  localparam int WEIGHT_W = 32;
  localparam int STATUS_W = 2;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_END   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTED   = 1'd1;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   src_node;
    logic [NODE_W-1:0]   dst_node;
    logic [WEIGHT_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   found_src;
    logic [NODE_W-1:0]   found_dst;
    logic [WEIGHT_W-1:0] found_weight;
  } out_item_t;

endpackage

`default_nettype wire

>>> hdl/amet_in_if.sv
`default_nettype none

interface amet_in_if;
  logic               valid;
  logic               ready;
  amet_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/amet_out_if.sv
`default_nettype none

interface amet_out_if;
  logic                valid;
  logic                ready;
  amet_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/amet_scan_unit.sv
`default_nettype none

// find-first over one matrix row, limited to columns in [col_start, bound)
module amet_scan_unit #(
  parameter int MAX_NODES = 16
) (
  input  wire logic [MAX_NODES-1:0]                row_bits,
  input  wire logic [$clog2(MAX_NODES)-1:0]        col_start,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]      bound,
  output logic                                     hit,
  output logic [$clog2(MAX_NODES)-1:0]             hit_col
);

  localparam int IW = $clog2(MAX_NODES);

  always_comb begin
    hit     = 1'b0;
    hit_col = '0;
    // walk downward so the lowest qualifying column wins
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (row_bits[i] && (i >= int'(col_start)) && (i < int'(bound))) begin
        hit     = 1'b1;
        hit_col = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/amet_weight_ram.sv
`default_nettype none

module amet_weight_ram #(
  parameter int DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [amet_pkg::WEIGHT_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [amet_pkg::WEIGHT_W-1:0]     rd_data
);

  logic [amet_pkg::WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/adjacency_matrix_edge_table_core.sv
// insert / remove: the request goes through the write state, then the mirror state when mirrored, then done
// (one weight memory write port, so the mirror entry needs a state of its own)
// search: the scan state steps through the rows until a hit or the end of the rows, then done;
// range error or next with no search: straight to done; one matrix row per cycle in the find-first unit
// next request taken the cycle after the result enters the output register, held while it is full
// reset (rst_n low, synchronous): no edges, no search active, node_count 16, directed 1
`default_nettype none

`include "assert_macros.svh"

module adjacency_matrix_edge_table_core #(
  parameter int MAX_NODES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  amet_in_if.sink                                in_ch,
  amet_out_if.source                             out_ch,
  input  wire logic                              cfg_wr_en,
  input  wire logic [amet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [amet_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MIRROR,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                             state_r;
  logic [amet_pkg::COUNT_W-1:0]       node_count_r;
  logic                               directed_r;
  logic [MAX_NODES-1:0]               edge_r [MAX_NODES];

  logic                               ins_r;
  logic [IW-1:0]                      src_r;
  logic [IW-1:0]                      dst_r;
  logic [amet_pkg::WEIGHT_W-1:0]      wgt_r;

  logic [NW-1:0]                      cur_row_r;
  logic [IW-1:0]                      cur_col_r;
  logic                               live_r;

  logic [amet_pkg::STATUS_W-1:0]      res_status_r;
  logic [amet_pkg::NODE_W-1:0]        res_src_r;
  logic [amet_pkg::NODE_W-1:0]        res_dst_r;
  logic                               use_weight_r;

  logic                               out_valid_r;
  amet_pkg::out_item_t                out_data_r;

  logic [NW-1:0]                      n_eff;
  logic                               in_fire;
  logic                               src_oor;
  logic                               dst_oor;
  logic                               row_done;
  logic                               scan_hit;
  logic [IW-1:0]                      scan_col;
  logic                               ram_wr_en;
  logic [AW-1:0]                      ram_wr_addr;
  logic [amet_pkg::WEIGHT_W-1:0]      ram_wr_data;
  logic                               ram_rd_en;
  logic [AW-1:0]                      ram_rd_addr;
  logic [amet_pkg::WEIGHT_W-1:0]      ram_rd_data;
  logic                               out_free;

  // effective vertex count, clamped to the matrix size
  assign n_eff = (int'(node_count_r) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count_r);

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign src_oor     = int'(in_ch.payload.src_node) >= int'(n_eff);
  assign dst_oor     = int'(in_ch.payload.dst_node) >= int'(n_eff);
  assign row_done    = int'(cur_row_r) >= int'(n_eff);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  amet_scan_unit #(
    .MAX_NODES (MAX_NODES)
  ) u_scan (
    .row_bits  (edge_r[cur_row_r[IW-1:0]]),
    .col_start (cur_col_r),
    .bound     (n_eff),
    .hit       (scan_hit),
    .hit_col   (scan_col)
  );

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = AW'(int'(src_r) * MAX_NODES + int'(dst_r));
    ram_wr_data = ins_r ? wgt_r : '0;
    if (state_r == ST_WRITE) begin
      ram_wr_en = 1'b1;
    end else if (state_r == ST_MIRROR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = AW'(int'(dst_r) * MAX_NODES + int'(src_r));
    end
  end

  assign ram_rd_en   = (state_r == ST_SCAN) && !row_done && scan_hit;
  assign ram_rd_addr = AW'(int'(cur_row_r[IW-1:0]) * MAX_NODES + int'(scan_col));

  amet_weight_ram #(
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= amet_pkg::NODE_COUNT_RST;
      directed_r   <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        amet_pkg::REG_NODE_COUNT: node_count_r <= cfg_wdata;
        amet_pkg::REG_DIRECTED:   directed_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      live_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int r = 0; r < MAX_NODES; r++) begin
        edge_r[r] <= '0;
      end
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            ins_r        <= (in_ch.payload.cmd == amet_pkg::CMD_INSERT);
            src_r        <= IW'(in_ch.payload.src_node);
            dst_r        <= IW'(in_ch.payload.dst_node);
            wgt_r        <= in_ch.payload.edge_weight;
            res_src_r    <= '0;
            res_dst_r    <= '0;
            use_weight_r <= 1'b0;
            case (in_ch.payload.cmd)
              amet_pkg::CMD_INSERT, amet_pkg::CMD_REMOVE: begin
                if (src_oor || dst_oor) begin
                  res_status_r <= amet_pkg::STATUS_RANGE;
                  state_r      <= ST_DONE;
                end else begin
                  res_status_r <= amet_pkg::STATUS_OK;
                  state_r      <= ST_WRITE;
                end
              end
              amet_pkg::CMD_START: begin
                if (src_oor) begin
                  live_r       <= 1'b0;
                  cur_row_r    <= '0;
                  cur_col_r    <= '0;
                  res_status_r <= amet_pkg::STATUS_RANGE;
                  state_r      <= ST_DONE;
                end else begin
                  live_r       <= 1'b1;
                  cur_row_r    <= NW'(in_ch.payload.src_node);
                  cur_col_r    <= '0;
                  res_status_r <= amet_pkg::STATUS_OK;
                  state_r      <= ST_SCAN;
                end
              end
              default: begin
                if (live_r) begin
                  res_status_r <= amet_pkg::STATUS_OK;
                  state_r      <= ST_SCAN;
                end else begin
                  res_status_r <= amet_pkg::STATUS_END;
                  state_r      <= ST_DONE;
                end
              end
            endcase
          end
        end
        ST_WRITE: begin
          edge_r[src_r][dst_r] <= ins_r;
          state_r <= directed_r ? ST_DONE : ST_MIRROR;
        end
        ST_MIRROR: begin
          edge_r[dst_r][src_r] <= ins_r;
          state_r <= ST_DONE;
        end
        ST_SCAN: begin
          if (row_done) begin
            // search exhausted
            live_r       <= 1'b0;
            cur_row_r    <= '0;
            cur_col_r    <= '0;
            res_status_r <= amet_pkg::STATUS_END;
            state_r      <= ST_DONE;
          end else if (scan_hit) begin
            res_src_r    <= amet_pkg::NODE_W'(cur_row_r);
            res_dst_r    <= amet_pkg::NODE_W'(scan_col);
            use_weight_r <= 1'b1;
            if ((int'(scan_col) + 1) >= int'(n_eff)) begin
              cur_row_r <= cur_row_r + 1'b1;
              cur_col_r <= '0;
            end else begin
              cur_col_r <= scan_col + 1'b1;
            end
            state_r <= ST_DONE;
          end else begin
            cur_row_r <= cur_row_r + 1'b1;
            cur_col_r <= '0;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r.status       <= res_status_r;
            out_data_r.found_src    <= res_src_r;
            out_data_r.found_dst    <= res_dst_r;
            out_data_r.found_weight <= use_weight_r ? ram_rd_data : '0;
            state_r                 <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `AMET_ASSERT(a_no_fields_without_hit, clk, rst_n,
    (out_ch.valid && (out_ch.payload.status != amet_pkg::STATUS_OK)) |->
    (out_ch.payload.found_weight == '0 && out_ch.payload.found_src == '0 &&
     out_ch.payload.found_dst == '0))
  `AMET_ASSERT(a_busy_after_request, clk, rst_n, in_fire |=> !in_ch.ready)
  `AMET_ASSERT(a_end_clears_search, clk, rst_n,
    (state_r == ST_SCAN && row_done) |=> (!live_r && cur_row_r == '0))
  `AMET_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE && !out_valid_r))

endmodule

`default_nettype wire
